// ===== hw/rtl/dwpm_pkg.sv =====
// Package for the double-well path Metropolis block.
// Holds the sequencer state type, item and register codes, and fixed-point constants.
// No dependencies.
package dwpm_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_UPDATE  = 2'd1,
    MODE_READ    = 2'd2,
    MODE_MEASURE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_SPACING = 2'd0,
    CFG_ETA     = 2'd1,
    CFG_ALPHA   = 2'd2,
    CFG_SITES   = 2'd3
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_U_RDX,
    ST_U_RDM,
    ST_U_RDP,
    ST_U_CAP,
    ST_C_ETA2,
    ST_C_OM,
    ST_L_K1,
    ST_L_K2,
    ST_L_KS,
    ST_L_KIN,
    ST_L_XX,
    ST_L_G,
    ST_L_D,
    ST_L_F,
    ST_L_G2,
    ST_L_F2,
    ST_L_V,
    ST_L_PA,
    ST_L_RES,
    ST_U_END,
    ST_M_RD,
    ST_M_CAP,
    ST_M_T,
    ST_M_PA,
    ST_M_S
  } st_e;

  localparam logic [63:0] ONE_Q24 = 64'd16777216;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  localparam logic [30:0] SPACING_RST = 31'd838861;
  localparam logic [30:0] ETA_RST     = 31'd23488102;
  localparam logic [24:0] ALPHA_RST   = 25'd0;
  localparam logic [10:0] SITES_RST   = 11'd1024;
  // floor(2^46 / a) for the reset spacing.
  localparam logic [46:0] INV4A_RST   = 47'((64'd1 << 46) / 64'd838861);
  localparam logic [5:0]  DIV_STEPS   = 6'd47;
  localparam logic [2:0]  MUL_LAST    = 3'd5;

endpackage

// ===== hw/rtl/dwpm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module dwpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/double_well_path_metropolis.sv =====
// Top level of the double-well path Metropolis block: sequencer, shared multiplier,
// spacing reciprocal divider and the path memory. Uses dwpm_pkg and dwpm_ram.
//
// The path lives in one RAM with a registered read port; every product goes through
// one shared 64x64 signed saturating multiplier built from four 32x32 partial
// products. A site write returns its result on the cycle after start; a site read
// passes through the ST_RD state and registers the stored value on the outputs. A
// Metropolis update runs 3 memory reads and a capture step, 2 constant products,
// then two local action passes of 9 products and 4 additions or subtractions each.
// An action measurement runs the 2 constant products, then visits each active site
// in turn. Writing the lattice spacing starts a reciprocal division, during which
// busy_o stays high. Results appear for one cycle on result_valid_o and cannot be
// stalled; a new start is taken while the last result is still on the outputs.
module double_well_path_metropolis #(
  parameter int MAX_SITES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         site_index_i,
  input  logic signed [31:0] site_value_i,
  input  logic signed [31:0] proposal_offset_i,
  input  logic [30:0]        accept_threshold_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [1:0]         done_mode_o,
  output logic [9:0]         done_site_o,
  output logic signed [31:0] result_value_o,
  output logic               accepted_o,
  output logic signed [63:0] action_difference_o
);

  localparam int AW = $clog2(MAX_SITES);
  localparam int NW = AW + 1;

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] p,
                                                input logic signed [63:0] q);
    logic signed [63:0] s;
    s = p + q;
    if (p[63] == q[63] && s[63] != p[63]) begin
      s = p[63] ? dwpm_pkg::S64_MIN : dwpm_pkg::S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] ssub64(input logic signed [63:0] p,
                                                input logic signed [63:0] q);
    logic signed [63:0] s;
    s = p - q;
    if (p[63] != q[63] && s[63] != p[63]) begin
      s = p[63] ? dwpm_pkg::S64_MIN : dwpm_pkg::S64_MAX;
    end
    return s;
  endfunction

  // Control state
  dwpm_pkg::st_e   state_q, state_d;
  logic [2:0]      ph_q, ph_d;
  logic [AW-1:0]   cursor_q;
  logic            pass_q;
  logic [NW-1:0]   k_q;
  logic            valid_q;

  // Configuration
  logic [30:0]     spacing_q;
  logic [30:0]     eta_q;
  logic [24:0]     mix_q;
  logic [10:0]     sites_q;
  logic [46:0]     inv4a_q;
  logic [30:0]     dsr_q;
  logic [30:0]     rem_q;
  logic [5:0]      div_cnt_q;

  // Item and datapath
  dwpm_pkg::mode_e mode_q;
  logic [9:0]      idx_q;
  logic            idx_ok_q;
  logic signed [31:0] off_q;
  logic [30:0]     thr_q;
  logic [AW-1:0]   ci_q, cip_q, cim_q;
  logic signed [31:0] x0_q, xm_q, xp_q, x1_q, xs_q;
  logic signed [63:0] etasq_q, half_q, k1_q, k2_q, ks_q, kin_q, xx_q, g_q, d_q, f_q;
  logic signed [63:0] v_q, pa_q, la1_q, la0_q, t_q, s_q;
  logic [63:0]     ma_q, mb_q;
  logic            neg_q;
  logic [127:0]    acc_q;

  // Output registers
  logic [1:0]         out_mode_q;
  logic [9:0]         out_site_q;
  logic signed [31:0] out_value_q;
  logic               out_acc_q;
  logic signed [63:0] out_diff_q;

  // RAM port
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  logic            div_busy, accept, idx_ok, mul_st, mul_last;
  logic [NW-1:0]   n_w;
  logic [AW-1:0]   i_w, ip_w, im_w;
  logic signed [63:0] oa, ob, mres, eta64, al64, onem64, dp64, dm64, ds64, fin_sum;
  logic [31:0]     pa_sel, pb_sel;
  logic [63:0]     pp;
  logic [127:0]    pp_sh;
  logic [63:0]     lim, mag;
  logic [32:0]     x1_sum;
  logic signed [31:0] x1_w;
  logic            keep;
  logic [31:0]     rem_s;

  assign div_busy = (div_cnt_q != 6'd0);
  assign busy_o   = (state_q != dwpm_pkg::ST_IDLE) || div_busy;
  assign accept   = start_i && !busy_o;
  assign idx_ok   = 32'(site_index_i) < 32'(MAX_SITES);

  // Active site count, clamped to two and to the store depth.
  always_comb begin
    if (sites_q < 11'd2) begin
      n_w = NW'(2);
    end else if (32'(sites_q) > 32'(MAX_SITES)) begin
      n_w = NW'(MAX_SITES);
    end else begin
      n_w = NW'(sites_q);
    end
  end

  assign i_w  = (NW'(cursor_q) < n_w) ? cursor_q : '0;
  assign ip_w = (NW'(i_w) + NW'(1) == n_w) ? '0 : AW'(i_w + AW'(1));
  assign im_w = (i_w == '0) ? AW'(n_w - NW'(1)) : AW'(i_w - AW'(1));

  // Trial value saturates to 32 bits.
  assign x1_sum = {x0_q[31], x0_q} + {off_q[31], off_q};
  always_comb begin
    if (x1_sum[32] != x1_sum[31]) begin
      x1_w = x1_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      x1_w = $signed(x1_sum[31:0]);
    end
  end

  assign eta64  = $signed(64'(eta_q));
  assign al64   = (64'(mix_q) > dwpm_pkg::ONE_Q24) ? $signed(dwpm_pkg::ONE_Q24)
                                                    : $signed(64'(mix_q));
  assign onem64 = $signed(dwpm_pkg::ONE_Q24) - al64;
  assign dp64   = 64'(xp_q) - 64'(xs_q);
  assign dm64   = 64'(xs_q) - 64'(xm_q);
  assign ds64   = ssub64(la1_q, la0_q);
  assign keep   = ds64 <= $signed({33'd0, thr_q});
  assign fin_sum = sadd64(s_q, pa_q);

  always_comb begin
    mul_st = 1'b0;
    case (state_q) inside
      dwpm_pkg::ST_C_ETA2, dwpm_pkg::ST_C_OM, dwpm_pkg::ST_L_K1, dwpm_pkg::ST_L_K2,
      dwpm_pkg::ST_L_KIN, dwpm_pkg::ST_L_XX, dwpm_pkg::ST_L_G, dwpm_pkg::ST_L_F,
      dwpm_pkg::ST_L_G2, dwpm_pkg::ST_L_F2, dwpm_pkg::ST_L_PA,
      dwpm_pkg::ST_M_PA: mul_st = 1'b1;
      default: mul_st = 1'b0;
    endcase
  end
  assign mul_last = mul_st && (ph_q == dwpm_pkg::MUL_LAST);

  // Multiplier operands per sequencer step.
  always_comb begin
    oa = '0;
    ob = '0;
    case (state_q)
      dwpm_pkg::ST_C_ETA2: begin oa = eta64; ob = eta64; end
      dwpm_pkg::ST_C_OM: begin oa = eta64 <<< 2; ob = eta64 <<< 2; end
      dwpm_pkg::ST_L_K1: begin oa = dp64; ob = dp64; end
      dwpm_pkg::ST_L_K2: begin oa = dm64; ob = dm64; end
      dwpm_pkg::ST_L_KIN: begin oa = $signed(64'(inv4a_q)); ob = ks_q; end
      dwpm_pkg::ST_L_XX: begin oa = 64'(xs_q); ob = 64'(xs_q); end
      dwpm_pkg::ST_L_G: begin oa = half_q; ob = xx_q; end
      dwpm_pkg::ST_L_F: begin oa = d_q; ob = d_q; end
      dwpm_pkg::ST_L_G2: begin oa = onem64; ob = g_q; end
      dwpm_pkg::ST_L_F2: begin oa = al64; ob = f_q; end
      dwpm_pkg::ST_L_PA: begin oa = $signed(64'(spacing_q)); ob = v_q; end
      dwpm_pkg::ST_M_PA: begin oa = $signed(64'(spacing_q)); ob = t_q; end
      default: begin oa = '0; ob = '0; end
    endcase
  end

  // Partial product of the current phase.
  always_comb begin
    pa_sel = ma_q[31:0];
    pb_sel = mb_q[31:0];
    case (ph_q)
      3'd2: begin pa_sel = ma_q[31:0];  pb_sel = mb_q[63:32]; end
      3'd3: begin pa_sel = ma_q[63:32]; pb_sel = mb_q[31:0];  end
      3'd4: begin pa_sel = ma_q[63:32]; pb_sel = mb_q[63:32]; end
      default: begin pa_sel = ma_q[31:0]; pb_sel = mb_q[31:0]; end
    endcase
    pp = 64'(pa_sel) * 64'(pb_sel);
    case (ph_q)
      3'd2, 3'd3: pp_sh = 128'(pp) << 32;
      3'd4: pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp);
    endcase
  end

  // Rescale by 2^-24 with saturation, then restore the sign.
  always_comb begin
    lim = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (acc_q[127:88] != '0) begin
      mag = lim;
    end else if (acc_q[87:24] > lim) begin
      mag = lim;
    end else begin
      mag = acc_q[87:24];
    end
    mres = neg_q ? $signed(64'd0 - mag) : $signed(mag);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    if (mul_st) begin
      ph_d = mul_last ? 3'd0 : ph_q + 3'd1;
    end
    case (state_q)
      dwpm_pkg::ST_IDLE: begin
        if (accept) begin
          case (dwpm_pkg::mode_e'(mode_i))
            dwpm_pkg::MODE_READ:    state_d = dwpm_pkg::ST_RD;
            dwpm_pkg::MODE_UPDATE:  state_d = dwpm_pkg::ST_U_RDX;
            dwpm_pkg::MODE_MEASURE: state_d = dwpm_pkg::ST_C_ETA2;
            default:                state_d = dwpm_pkg::ST_IDLE;
          endcase
        end
      end
      dwpm_pkg::ST_RD:    state_d = dwpm_pkg::ST_IDLE;
      dwpm_pkg::ST_U_RDX: state_d = dwpm_pkg::ST_U_RDM;
      dwpm_pkg::ST_U_RDM: state_d = dwpm_pkg::ST_U_RDP;
      dwpm_pkg::ST_U_RDP: state_d = dwpm_pkg::ST_U_CAP;
      dwpm_pkg::ST_U_CAP: state_d = dwpm_pkg::ST_C_ETA2;
      dwpm_pkg::ST_C_ETA2: if (mul_last) state_d = dwpm_pkg::ST_C_OM;
      dwpm_pkg::ST_C_OM: begin
        if (mul_last) begin
          state_d = (mode_q == dwpm_pkg::MODE_MEASURE) ? dwpm_pkg::ST_M_RD
                                                       : dwpm_pkg::ST_L_K1;
        end
      end
      dwpm_pkg::ST_L_K1:  if (mul_last) state_d = dwpm_pkg::ST_L_K2;
      dwpm_pkg::ST_L_K2:  if (mul_last) state_d = dwpm_pkg::ST_L_KS;
      dwpm_pkg::ST_L_KS:  state_d = dwpm_pkg::ST_L_KIN;
      dwpm_pkg::ST_L_KIN: if (mul_last) state_d = dwpm_pkg::ST_L_XX;
      dwpm_pkg::ST_L_XX:  if (mul_last) state_d = dwpm_pkg::ST_L_G;
      dwpm_pkg::ST_L_G:   if (mul_last) state_d = dwpm_pkg::ST_L_D;
      dwpm_pkg::ST_L_D:   state_d = dwpm_pkg::ST_L_F;
      dwpm_pkg::ST_L_F: begin
        if (mul_last) begin
          state_d = (mode_q == dwpm_pkg::MODE_MEASURE) ? dwpm_pkg::ST_M_T
                                                       : dwpm_pkg::ST_L_G2;
        end
      end
      dwpm_pkg::ST_L_G2:  if (mul_last) state_d = dwpm_pkg::ST_L_F2;
      dwpm_pkg::ST_L_F2:  if (mul_last) state_d = dwpm_pkg::ST_L_V;
      dwpm_pkg::ST_L_V:   state_d = dwpm_pkg::ST_L_PA;
      dwpm_pkg::ST_L_PA:  if (mul_last) state_d = dwpm_pkg::ST_L_RES;
      dwpm_pkg::ST_L_RES: state_d = pass_q ? dwpm_pkg::ST_U_END : dwpm_pkg::ST_L_K1;
      dwpm_pkg::ST_U_END: state_d = dwpm_pkg::ST_IDLE;
      dwpm_pkg::ST_M_RD:  state_d = dwpm_pkg::ST_M_CAP;
      dwpm_pkg::ST_M_CAP: state_d = dwpm_pkg::ST_L_XX;
      dwpm_pkg::ST_M_T:   state_d = dwpm_pkg::ST_M_PA;
      dwpm_pkg::ST_M_PA:  if (mul_last) state_d = dwpm_pkg::ST_M_S;
      dwpm_pkg::ST_M_S: begin
        state_d = (k_q + NW'(1) == n_w) ? dwpm_pkg::ST_IDLE : dwpm_pkg::ST_M_RD;
      end
      default: state_d = dwpm_pkg::ST_IDLE;
    endcase
  end

  // Memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ci_q;
    ram_wdata = x1_q;
    ram_raddr = ci_q;
    case (state_q)
      dwpm_pkg::ST_IDLE: begin
        ram_we    = accept && (dwpm_pkg::mode_e'(mode_i) == dwpm_pkg::MODE_WRITE) && idx_ok;
        ram_waddr = AW'(site_index_i);
        ram_wdata = site_value_i;
        ram_raddr = AW'(site_index_i);
      end
      dwpm_pkg::ST_U_RDX: ram_raddr = ci_q;
      dwpm_pkg::ST_U_RDM: ram_raddr = cim_q;
      dwpm_pkg::ST_U_RDP: ram_raddr = cip_q;
      dwpm_pkg::ST_M_RD:  ram_raddr = k_q[AW-1:0];
      dwpm_pkg::ST_U_END: ram_we = keep;
      default: ram_raddr = ci_q;
    endcase
  end

  dwpm_ram #(
    .WIDTH(32),
    .DEPTH(MAX_SITES)
  ) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rem_s = {rem_q, div_cnt_q == dwpm_pkg::DIV_STEPS};

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dwpm_pkg::ST_IDLE;
      ph_q      <= 3'd0;
      cursor_q  <= '0;
      pass_q    <= 1'b0;
      k_q       <= '0;
      valid_q   <= 1'b0;
      spacing_q <= dwpm_pkg::SPACING_RST;
      eta_q     <= dwpm_pkg::ETA_RST;
      mix_q     <= dwpm_pkg::ALPHA_RST;
      sites_q   <= dwpm_pkg::SITES_RST;
      inv4a_q   <= dwpm_pkg::INV4A_RST;
      dsr_q     <= 31'd1;
      rem_q     <= '0;
      div_cnt_q <= 6'd0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      valid_q <= (accept && dwpm_pkg::mode_e'(mode_i) == dwpm_pkg::MODE_WRITE)
              || (state_q == dwpm_pkg::ST_RD) || (state_q == dwpm_pkg::ST_U_END)
              || (state_q == dwpm_pkg::ST_M_S && state_d == dwpm_pkg::ST_IDLE);
      if (accept) begin
        pass_q <= 1'b0;
        k_q    <= '0;
      end
      if (state_q == dwpm_pkg::ST_L_RES) begin
        pass_q <= 1'b1;
      end
      if (state_q == dwpm_pkg::ST_M_S) begin
        k_q <= k_q + NW'(1);
      end
      if (state_q == dwpm_pkg::ST_U_END) begin
        cursor_q <= cip_q;
      end

      // Restoring division of 2^46 by the spacing, one quotient bit per cycle.
      if (div_busy) begin
        div_cnt_q <= div_cnt_q - 6'd1;
        if (rem_s >= {1'b0, dsr_q}) begin
          rem_q   <= 31'(rem_s - {1'b0, dsr_q});
          inv4a_q <= {inv4a_q[45:0], 1'b1};
        end else begin
          rem_q   <= rem_s[30:0];
          inv4a_q <= {inv4a_q[45:0], 1'b0};
        end
      end

      if (cfg_we_i) begin
        case (dwpm_pkg::cfg_e'(cfg_index_i))
          dwpm_pkg::CFG_SPACING: begin
            spacing_q <= cfg_data_i;
            dsr_q     <= (cfg_data_i == '0) ? 31'd1 : cfg_data_i;
            rem_q     <= '0;
            inv4a_q   <= '0;
            div_cnt_q <= dwpm_pkg::DIV_STEPS;
          end
          dwpm_pkg::CFG_ETA:   eta_q   <= cfg_data_i;
          dwpm_pkg::CFG_ALPHA: mix_q   <= cfg_data_i[24:0];
          dwpm_pkg::CFG_SITES: sites_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= dwpm_pkg::mode_e'(mode_i);
      idx_q    <= site_index_i;
      idx_ok_q <= idx_ok;
      off_q    <= proposal_offset_i;
      thr_q    <= accept_threshold_i;
      ci_q     <= i_w;
      cip_q    <= ip_w;
      cim_q    <= im_w;
      s_q      <= '0;
      if (dwpm_pkg::mode_e'(mode_i) == dwpm_pkg::MODE_WRITE) begin
        out_mode_q  <= mode_i;
        out_site_q  <= site_index_i;
        out_value_q <= idx_ok ? site_value_i : 32'sd0;
        out_acc_q   <= 1'b0;
        out_diff_q  <= '0;
      end
    end

    if (mul_st) begin
      if (ph_q == 3'd0) begin
        ma_q  <= oa[63] ? 64'd0 - oa : oa;
        mb_q  <= ob[63] ? 64'd0 - ob : ob;
        neg_q <= oa[63] ^ ob[63];
        acc_q <= '0;
      end else if (!mul_last) begin
        acc_q <= acc_q + pp_sh;
      end
    end

    if (mul_last) begin
      case (state_q)
        dwpm_pkg::ST_C_ETA2: etasq_q <= mres;
        dwpm_pkg::ST_C_OM:   half_q  <= mres >>> 1;
        dwpm_pkg::ST_L_K1:   k1_q    <= mres;
        dwpm_pkg::ST_L_K2:   k2_q    <= mres;
        dwpm_pkg::ST_L_KIN:  kin_q   <= mres;
        dwpm_pkg::ST_L_XX:   xx_q    <= mres;
        dwpm_pkg::ST_L_G,
        dwpm_pkg::ST_L_G2:   g_q     <= mres;
        dwpm_pkg::ST_L_F,
        dwpm_pkg::ST_L_F2:   f_q     <= mres;
        dwpm_pkg::ST_L_PA,
        dwpm_pkg::ST_M_PA:   pa_q    <= mres;
        default: ;
      endcase
    end

    case (state_q)
      dwpm_pkg::ST_RD: begin
        out_mode_q  <= mode_q;
        out_site_q  <= idx_q;
        out_value_q <= idx_ok_q ? $signed(ram_rdata) : 32'sd0;
        out_acc_q   <= 1'b0;
        out_diff_q  <= '0;
      end
      dwpm_pkg::ST_U_RDM: x0_q <= ram_rdata;
      dwpm_pkg::ST_U_RDP: xm_q <= ram_rdata;
      dwpm_pkg::ST_U_CAP: begin
        xp_q <= ram_rdata;
        x1_q <= x1_w;
        xs_q <= x1_w;
      end
      dwpm_pkg::ST_L_KS: ks_q <= sadd64(k1_q, k2_q);
      dwpm_pkg::ST_L_D:  d_q  <= ssub64(xx_q, etasq_q);
      dwpm_pkg::ST_L_V:  v_q  <= sadd64(g_q, f_q);
      dwpm_pkg::ST_L_RES: begin
        // The trial value is evaluated first, then the current one.
        if (!pass_q) begin
          la1_q <= sadd64(kin_q, pa_q);
          xs_q  <= x0_q;
        end else begin
          la0_q <= sadd64(kin_q, pa_q);
        end
      end
      dwpm_pkg::ST_U_END: begin
        out_mode_q  <= mode_q;
        out_site_q  <= 10'(ci_q);
        out_value_q <= keep ? x1_q : x0_q;
        out_acc_q   <= keep;
        out_diff_q  <= '0;
      end
      dwpm_pkg::ST_M_CAP: xs_q <= ram_rdata;
      dwpm_pkg::ST_M_T:   t_q  <= ssub64(f_q, g_q);
      dwpm_pkg::ST_M_S: begin
        s_q         <= fin_sum;
        out_mode_q  <= mode_q;
        out_site_q  <= '0;
        out_value_q <= '0;
        out_acc_q   <= 1'b0;
        out_diff_q  <= fin_sum;
      end
      default: ;
    endcase
  end

  assign result_valid_o      = valid_q;
  assign done_mode_o         = out_mode_q;
  assign done_site_o         = out_site_q;
  assign result_value_o      = out_value_q;
  assign accepted_o          = out_acc_q;
  assign action_difference_o = out_diff_q;

endmodule

// ===== tb/dwpm_checker.sv =====
// Checker for the double-well path Metropolis block: watches the item, register and
// result ports, predicts every result and compares it. Depends on dwpm_pkg.
module dwpm_checker #(
  parameter int MAX_SITES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         site_index_i,
  input  logic signed [31:0] site_value_i,
  input  logic signed [31:0] proposal_offset_i,
  input  logic [30:0]        accept_threshold_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               result_valid_i,
  input  logic [1:0]         done_mode_i,
  input  logic [9:0]         done_site_i,
  input  logic signed [31:0] result_value_i,
  input  logic               accepted_i,
  input  logic signed [63:0] action_difference_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         site;
    logic signed [31:0] value;
    logic               acc;
    logic signed [63:0] diff;
  } outcome_t;

  outcome_t           outcome_q[$];
  logic signed [31:0] path_mem[MAX_SITES];
  int                 cursor;
  longint             spacing, eta, alpha_raw, sites_raw, inv4a;

  function automatic longint sat_add(longint p, longint q);
    logic signed [64:0] s;
    s = {p[63], p} + {q[63], q};
    if (s[64] != s[63]) return s[64] ? dwpm_pkg::S64_MIN : dwpm_pkg::S64_MAX;
    return s[63:0];
  endfunction

  function automatic longint sat_sub(longint p, longint q);
    logic signed [64:0] s;
    s = {p[63], p} - {q[63], q};
    if (s[64] != s[63]) return s[64] ? dwpm_pkg::S64_MIN : dwpm_pkg::S64_MAX;
    return s[63:0];
  endfunction

  // Q.24 product of magnitudes, truncated toward zero, sign restored, saturated.
  function automatic longint q_mul(longint p, longint q);
    logic         neg;
    logic [63:0]  up, uq, lim;
    logic [127:0] mag;
    neg = (p < 0) != (q < 0);
    up  = (p < 0) ? -p : p;
    uq  = (q < 0) ? -q : q;
    mag = ({64'd0, up} * {64'd0, uq}) >> 24;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (mag > {64'd0, lim}) mag = {64'd0, lim};
    return neg ? -mag[63:0] : mag[63:0];
  endfunction

  function automatic longint gauss_pot(longint x);
    longint om, half;
    om   = sat_add(sat_add(eta, eta), sat_add(eta, eta));
    half = q_mul(om, om) / 2;
    return q_mul(half, q_mul(x, x));
  endfunction

  function automatic longint well_pot(longint x);
    longint d;
    d = sat_sub(q_mul(x, x), q_mul(eta, eta));
    return q_mul(d, d);
  endfunction

  function automatic longint site_action(longint x, longint xm, longint xp);
    longint al, kin, v;
    al  = (alpha_raw > 64'd16777216) ? 64'd16777216 : alpha_raw;
    kin = q_mul(inv4a, sat_add(q_mul(xp - x, xp - x), q_mul(x - xm, x - xm)));
    v   = sat_add(q_mul(64'd16777216 - al, gauss_pot(x)), q_mul(al, well_pot(x)));
    return sat_add(kin, q_mul(spacing, v));
  endfunction

  function automatic void set_spacing(longint v);
    spacing = v;
    inv4a   = (64'd1 << 46) / ((v == 0) ? 64'd1 : v);
  endfunction

  function automatic outcome_t apply_item(logic [1:0] m, logic [9:0] idx,
                                          logic signed [31:0] val, logic signed [31:0] off,
                                          logic [30:0] thr);
    outcome_t r;
    int       n, i, ip, im;
    longint   x0, x1, xm, xp, ds, s;
    r = '0;
    r.mode = m;
    n = (sites_raw < 2) ? 2 : (sites_raw > MAX_SITES) ? MAX_SITES : int'(sites_raw);
    case (dwpm_pkg::mode_e'(m))
      dwpm_pkg::MODE_WRITE, dwpm_pkg::MODE_READ: begin
        r.site = idx;
        if (m == dwpm_pkg::MODE_WRITE) path_mem[idx] = val;
        r.value = path_mem[idx];
      end
      dwpm_pkg::MODE_UPDATE: begin
        i  = (cursor < n) ? cursor : 0;
        ip = (i + 1 == n) ? 0 : i + 1;
        im = (i == 0) ? n - 1 : i - 1;
        x0 = path_mem[i];
        xm = path_mem[im];
        xp = path_mem[ip];
        x1 = x0 + longint'(off);
        if (x1 > 64'sd2147483647) x1 = 64'sd2147483647;
        if (x1 < -64'sd2147483648) x1 = -64'sd2147483648;
        ds = sat_sub(site_action(x1, xm, xp), site_action(x0, xm, xp));
        if (ds <= longint'({33'd0, thr})) begin
          path_mem[i] = x1[31:0];
          r.acc = 1'b1;
        end
        r.value = path_mem[i];
        r.site  = i[9:0];
        cursor  = ip;
      end
      default: begin
        s = 0;
        for (int k = 0; k < n; k++) begin
          x0 = path_mem[k];
          s  = sat_add(s, q_mul(spacing, sat_sub(well_pot(x0), gauss_pot(x0))));
        end
        r.diff = s;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      outcome_q.delete();
      foreach (path_mem[k]) path_mem[k] = '0;
      cursor    = 0;
      set_spacing(longint'(dwpm_pkg::SPACING_RST));
      eta       = dwpm_pkg::ETA_RST;
      alpha_raw = dwpm_pkg::ALPHA_RST;
      sites_raw = dwpm_pkg::SITES_RST;
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      // The result of an older item may leave in the same cycle a new item is taken.
      if (result_valid_i) begin
        if (outcome_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result transfer, mode %0d", done_mode_i);
        end else begin
          want = outcome_q.pop_front();
          checked_o++;
          if (done_mode_i !== want.mode || done_site_i !== want.site ||
              result_value_i !== want.value || accepted_i !== want.acc ||
              action_difference_i !== want.diff) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch: exp mode %0d site %0d val %0d acc %0b diff %0d",
                       want.mode, want.site, want.value, want.acc, want.diff);
              $display("          got mode %0d site %0d val %0d acc %0b diff %0d",
                       done_mode_i, done_site_i, result_value_i, accepted_i,
                       action_difference_i);
            end
          end
        end
      end
      if (start_i && !busy_i)
        outcome_q.push_back(apply_item(mode_i, site_index_i, site_value_i,
                                       proposal_offset_i, accept_threshold_i));
      if (cfg_we_i) begin
        case (dwpm_pkg::cfg_e'(cfg_index_i))
          dwpm_pkg::CFG_SPACING: set_spacing(longint'(cfg_data_i));
          dwpm_pkg::CFG_ETA:     eta = cfg_data_i;
          dwpm_pkg::CFG_ALPHA:   alpha_raw = cfg_data_i[24:0];
          dwpm_pkg::CFG_SITES:   sites_raw = cfg_data_i[10:0];
          default: ;
        endcase
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for double_well_path_metropolis: clock, reset, item and register
// stimulus, watchdog and verdict. Depends on dwpm_pkg and dwpm_checker.
module tb_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         mode_i = '0;
  logic [9:0]         site_index_i = '0;
  logic signed [31:0] site_value_i = '0;
  logic signed [31:0] proposal_offset_i = '0;
  logic [30:0]        accept_threshold_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [30:0]        cfg_data_i = '0;
  logic               result_valid_o;
  logic [1:0]         done_mode_o;
  logic [9:0]         done_site_o;
  logic signed [31:0] result_value_o;
  logic               accepted_o;
  logic signed [63:0] action_difference_o;

  int fail_count, pending, checked;
  int idle_pct, items_sent, watch_cnt, cur_sites;

  always #2 clk_i = ~clk_i;

  double_well_path_metropolis u_dut (.*);

  dwpm_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .site_index_i, .site_value_i,
    .proposal_offset_i, .accept_threshold_i, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .result_valid_i(result_valid_o), .done_mode_i(done_mode_o), .done_site_i(done_site_o),
    .result_value_i(result_value_o), .accepted_i(accepted_o),
    .action_difference_i(action_difference_o), .fail_count_o(fail_count),
    .pending_o(pending), .checked_o(checked)
  );

  // A full-length measurement makes no transfer while it runs; the watchdog counts cycles with no start or result.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt > 200000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_op(dwpm_pkg::mode_e m, logic [9:0] idx, logic [31:0] v,
                         logic [31:0] off, logic [30:0] thr);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    mode_i = m;
    site_index_i = idx;
    site_value_i = v;
    proposal_offset_i = off;
    accept_threshold_i = thr;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic reg_write(dwpm_pkg::cfg_e idx, logic [30:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    if (idx == dwpm_pkg::CFG_SITES)
      cur_sites = (data[10:0] < 2) ? 2 : (data[10:0] > 1024) ? 1024 : data[10:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] rnd_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return {1'($urandom_range(1)), 31'h7fff_ffff}
                      ^ {1'b0, {31{$urandom_range(1) == 1}}};
      default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  function automatic logic [30:0] rnd_thr();
    return ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0400_0000));
  endfunction

  task automatic random_regs();
    reg_write(dwpm_pkg::CFG_SPACING, ($urandom_range(3) == 0) ? 31'($urandom)
                                     : 31'($urandom_range(1 << 18, 1 << 22)));
    reg_write(dwpm_pkg::CFG_ETA, ($urandom_range(3) == 0) ? 31'($urandom)
                                 : 31'($urandom_range(0, 1 << 26)));
    reg_write(dwpm_pkg::CFG_ALPHA, ($urandom_range(3) == 0) ? 31'($urandom_range(0, 25'h1ff_ffff))
                                   : 31'($urandom_range(0, 1 << 24)));
    reg_write(dwpm_pkg::CFG_SITES, ($urandom_range(5) == 0) ? 31'($urandom_range(0, 2047))
                                   : 31'($urandom_range(2, 40)));
  endtask

  task automatic random_items(int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 25)
        send_op(dwpm_pkg::MODE_WRITE, 10'($urandom), rnd_value(), $urandom,
                31'($urandom));
      else if (pick < 65)
        send_op(dwpm_pkg::MODE_UPDATE, 10'($urandom), $urandom, rnd_value(), rnd_thr());
      else if (pick < 87 || (cur_sites > 64 && pick < 98))
        send_op(dwpm_pkg::MODE_READ, 10'($urandom), $urandom, $urandom, 31'($urandom));
      else
        send_op(dwpm_pkg::MODE_MEASURE, 10'($urandom), $urandom, $urandom,
                31'($urandom));
    end
  endtask

  initial begin
    items_sent = 0;
    watch_cnt = 0;
    cur_sites = 1024;
    idle_pct = 20;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every site gets a value first, so no read ever touches unwritten storage.
    for (int k = 0; k < 1024; k++)
      send_op(dwpm_pkg::MODE_WRITE, k[9:0], rnd_value(), '0, '0);

    // Directed: full-size path with extreme spacing and eta, alpha above one.
    reg_write(dwpm_pkg::CFG_SITES, 31'd2047);
    reg_write(dwpm_pkg::CFG_SPACING, 31'h7fff_ffff);
    reg_write(dwpm_pkg::CFG_ETA, '0);
    reg_write(dwpm_pkg::CFG_ALPHA, 31'h1ff_ffff);
    send_op(dwpm_pkg::MODE_WRITE, 10'd0, 32'h7fff_ffff, '0, '0);
    send_op(dwpm_pkg::MODE_WRITE, 10'd1023, 32'h8000_0000, '0, '0);
    send_op(dwpm_pkg::MODE_READ, 10'd0, '0, '0, '0);
    send_op(dwpm_pkg::MODE_READ, 10'd1023, '0, '0, '0);
    send_op(dwpm_pkg::MODE_UPDATE, '0, '0, 32'h7fff_ffff, 31'h7fff_ffff);
    send_op(dwpm_pkg::MODE_UPDATE, '0, '0, 32'h8000_0000, 31'h7fff_ffff);
    send_op(dwpm_pkg::MODE_UPDATE, '0, '0, 32'h8000_0000, '0);
    send_op(dwpm_pkg::MODE_UPDATE, '0, '0, '0, '0);
    send_op(dwpm_pkg::MODE_MEASURE, '0, '0, '0, '0);
    // The cursor now sits past a two-site path; spacing zero, eta maximal.
    reg_write(dwpm_pkg::CFG_SITES, 31'd0);
    reg_write(dwpm_pkg::CFG_SPACING, '0);
    reg_write(dwpm_pkg::CFG_ETA, 31'h7fff_ffff);
    reg_write(dwpm_pkg::CFG_ALPHA, 31'd16777216);
    send_op(dwpm_pkg::MODE_UPDATE, '0, '0, 32'h0100_0000, 31'h7fff_ffff);
    send_op(dwpm_pkg::MODE_UPDATE, '0, '0, 32'hff00_0000, '0);
    send_op(dwpm_pkg::MODE_MEASURE, '0, '0, '0, '0);
    reg_write(dwpm_pkg::CFG_SITES, 31'd1);
    reg_write(dwpm_pkg::CFG_SPACING, 31'd1);
    reg_write(dwpm_pkg::CFG_ETA, 31'd23488102);
    reg_write(dwpm_pkg::CFG_ALPHA, '0);
    send_op(dwpm_pkg::MODE_UPDATE, '0, '0, 32'h0080_0000, 31'h0100_0000);
    send_op(dwpm_pkg::MODE_MEASURE, '0, '0, '0, '0);
    send_op(dwpm_pkg::MODE_READ, 10'h2aa, '0, '0, '0);
    send_op(dwpm_pkg::MODE_READ, 10'h155, '0, '0, '0);

    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = (seg < 2) ? 20 : (seg < 4) ? 62 : 0;
      random_regs();
      random_items(85);
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d items (writes, reads, Metropolis updates, action measurements)",
             items_sent);
    $display("under varied register settings; %0d results compared.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
